@@ hdl/srs_pkg.sv @@
// Shared types, constants and helpers for the stable record sorter.
// No dependencies; used by every module of the block.
`default_nettype none
package srs_pkg;

  localparam int MaxRecords    = 1024;
  localparam int MaxFieldBytes = 8;
  localparam int IdxW          = $clog2(MaxRecords);
  localparam int CntW          = IdxW + 1;

  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_PUT   = 3'd1,
    KIND_FLUSH = 3'd2,
    KIND_ENUM  = 3'd3,
    KIND_NEXT  = 3'd4,
    KIND_CLOSE = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ERROR        = 3'd1,
    ST_INVALID_KEY  = 3'd2,
    ST_INVALID_DATA = 3'd3,
    ST_END          = 3'd4,
    ST_FULL         = 3'd5
  } status_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic        key_bad;
    logic        data_bad;
    logic [63:0] key;
    logic [63:0] data;
  } cmd_t;

  typedef struct packed {
    logic        done;
    logic [2:0]  status;
    logic        record_valid;
    logic [63:0] key;
    logic [63:0] data;
  } res_t;

  // keep the top 'bytes' bytes of a left-aligned key
  function automatic logic [63:0] top_bytes_mask(input logic [3:0] bytes);
    logic [63:0] m;
    if (bytes == 4'd0) m = 64'd0;
    else if (bytes >= 4'd8) m = '1;
    else m = ~64'd0 << (7'd64 - {bytes[2:0], 3'b000});
    return m;
  endfunction

endpackage
`default_nettype wire

@@ hdl/srs_front.sv @@
// Front end: configuration registers, command decode and a two-word queue.
// Depends on srs_pkg.
`default_nettype none
module srs_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [2:0]        kind_i,
  input  wire logic [63:0]       record_key_i,
  input  wire logic [3:0]        key_size_i,
  input  wire logic [63:0]       record_data_i,
  input  wire logic [3:0]        data_size_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [3:0]        cfg_index_i,
  input  wire logic [3:0]        cfg_data_i,
  output logic                   cmd_valid_o,
  output srs_pkg::cmd_t          cmd_o,
  input  wire logic              cmd_pop_i
);

  logic [3:0] key_len_q, data_len_q;
  srs_pkg::cmd_t q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push;
  srs_pkg::cmd_t new_cmd;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (fill_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];

  // classify the put checks up front
  always_comb begin
    new_cmd.kind     = kind_i;
    new_cmd.key_bad  = (key_size_i != key_len_q) ||
                       (key_size_i > 4'(srs_pkg::MaxFieldBytes));
    new_cmd.data_bad = (data_size_i != data_len_q) ||
                       (data_size_i > 4'(srs_pkg::MaxFieldBytes));
    new_cmd.key      = record_key_i & srs_pkg::top_bytes_mask(key_size_i);
    new_cmd.data     = record_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q  <= '0;
      data_len_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == 4'd0) key_len_q <= cfg_data_i;
      else if (cfg_index_i == 4'd1) data_len_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= new_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (cmd_pop_i) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule
`default_nettype wire

@@ hdl/srs_back.sv @@
// Back end: session state, record memories, rank sort sequencer, read path.
// Depends on srs_pkg.
`default_nettype none
module srs_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire srs_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output srs_pkg::res_t      res_o
);

  localparam int IdxW = srs_pkg::IdxW;
  localparam int CntW = srs_pkg::CntW;

  typedef enum logic [2:0] {
    S_IDLE, S_SORT_I, S_SORT_KI, S_SCAN, S_RD_IDX, S_RD_REC
  } state_e;

  state_e state_q;
  logic   open_q, done_q;
  logic [CntW-1:0] count_q, cursor_q, cursor_nx;
  logic [IdxW-1:0] i_q, j_q, rank_q, rank_nx;
  logic [63:0]     keyi_q;
  srs_pkg::res_t   res_q;

  logic [63:0]     key_mem  [srs_pkg::MaxRecords];
  logic [63:0]     data_mem [srs_pkg::MaxRecords];
  logic [IdxW-1:0] order_mem[srs_pkg::MaxRecords];
  logic [63:0]     key_rd_q, data_rd_q;
  logic [IdxW-1:0] order_rd_q;

  logic            take, put_we, scan_hit, scan_last, order_we;
  logic            sess_err, rd_err;
  logic [IdxW-1:0] key_raddr, order_raddr;

  assign take      = (state_q == S_IDLE) && cmd_valid_i;
  assign cmd_pop_o = take;
  assign res_o     = res_q;
  assign cursor_nx = cursor_q + 1'b1;
  assign sess_err  = !open_q || done_q;
  assign rd_err    = !open_q || !done_q;

  assign put_we = take && (cmd_i.kind == srs_pkg::KIND_PUT) && !sess_err &&
                  !cmd_i.key_bad && !cmd_i.data_bad &&
                  (count_q != CntW'(srs_pkg::MaxRecords));

  assign scan_hit  = (key_rd_q < keyi_q) || ((key_rd_q == keyi_q) && (j_q < i_q));
  assign rank_nx   = rank_q + IdxW'(scan_hit);
  assign scan_last = (state_q == S_SCAN) && ({1'b0, j_q} == count_q - 1'b1);
  assign order_we  = scan_last;

  always_comb begin
    case (state_q)
      S_SORT_I:  key_raddr = i_q;
      S_SCAN:    key_raddr = j_q + 1'b1;
      S_RD_IDX:  key_raddr = order_rd_q;
      default:   key_raddr = '0;
    endcase
    order_raddr = (cmd_i.kind == srs_pkg::KIND_NEXT) ? cursor_nx[IdxW-1:0]
                                                     : cursor_q[IdxW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (put_we) begin
      key_mem[count_q[IdxW-1:0]]  <= cmd_i.key;
      data_mem[count_q[IdxW-1:0]] <= cmd_i.data;
    end
    key_rd_q  <= key_mem[key_raddr];
    data_rd_q <= data_mem[key_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (order_we) order_mem[rank_nx] <= i_q;
    order_rd_q <= order_mem[order_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      open_q   <= 1'b0;
      done_q   <= 1'b0;
      count_q  <= '0;
      cursor_q <= '0;
      i_q      <= '0;
      j_q      <= '0;
      rank_q   <= '0;
      keyi_q   <= '0;
      res_q    <= '0;
    end else begin
      res_q <= '0;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            res_q.done   <= 1'b1;
            res_q.status <= srs_pkg::ST_ERROR;
            case (srs_pkg::kind_e'(cmd_i.kind))
              srs_pkg::KIND_OPEN: begin
                if (!open_q) begin
                  open_q <= 1'b1; done_q <= 1'b0;
                  count_q <= '0; cursor_q <= '0;
                  res_q.status <= srs_pkg::ST_OK;
                end
              end
              srs_pkg::KIND_PUT: begin
                if (sess_err) res_q.status <= srs_pkg::ST_ERROR;
                else if (cmd_i.key_bad) res_q.status <= srs_pkg::ST_INVALID_KEY;
                else if (cmd_i.data_bad) res_q.status <= srs_pkg::ST_INVALID_DATA;
                else if (!put_we) res_q.status <= srs_pkg::ST_FULL;
                else begin
                  count_q <= count_q + 1'b1;
                  res_q.status <= srs_pkg::ST_OK;
                end
              end
              srs_pkg::KIND_FLUSH: begin
                if (!sess_err) begin
                  done_q <= 1'b1; cursor_q <= '0; i_q <= '0;
                  if (count_q == '0) res_q.status <= srs_pkg::ST_OK;
                  else begin
                    res_q.done <= 1'b0;
                    state_q    <= S_SORT_I;
                  end
                end
              end
              srs_pkg::KIND_ENUM: begin
                if (!rd_err) begin
                  if (cursor_q >= count_q) res_q.status <= srs_pkg::ST_END;
                  else begin
                    res_q.done <= 1'b0;
                    state_q    <= S_RD_IDX;
                  end
                end
              end
              srs_pkg::KIND_NEXT: begin
                if (!rd_err) begin
                  if (cursor_q >= count_q) res_q.status <= srs_pkg::ST_END;
                  else begin
                    cursor_q <= cursor_nx;
                    if (cursor_nx >= count_q) res_q.status <= srs_pkg::ST_END;
                    else begin
                      res_q.done <= 1'b0;
                      state_q    <= S_RD_IDX;
                    end
                  end
                end
              end
              srs_pkg::KIND_CLOSE: begin
                if (open_q) begin
                  open_q <= 1'b0; done_q <= 1'b0;
                  count_q <= '0; cursor_q <= '0;
                  res_q.status <= srs_pkg::ST_OK;
                end
              end
              default: res_q.status <= srs_pkg::ST_ERROR;
            endcase
          end
        end
        S_SORT_I: state_q <= S_SORT_KI;
        S_SORT_KI: begin
          keyi_q  <= key_rd_q;
          j_q     <= '0;
          rank_q  <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          rank_q <= rank_nx;
          j_q    <= j_q + 1'b1;
          if (scan_last) begin
            i_q <= i_q + 1'b1;
            if ({1'b0, i_q} == count_q - 1'b1) begin
              res_q.done   <= 1'b1;
              res_q.status <= srs_pkg::ST_OK;
              state_q      <= S_IDLE;
            end else begin
              state_q <= S_SORT_I;
            end
          end
        end
        S_RD_IDX: state_q <= S_RD_REC;
        S_RD_REC: begin
          res_q.done         <= 1'b1;
          res_q.status       <= srs_pkg::ST_OK;
          res_q.record_valid <= 1'b1;
          res_q.key          <= key_rd_q;
          res_q.data         <= data_rd_q;
          state_q            <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/stable_record_sorter_unit.sv @@
// Top level of the stable record sorter: front queue plus back executor.
// Depends on srs_pkg, srs_front and srs_back.
//
// Commands enter while busy_o is low and queue two deep in the front; each
// gives exactly one result, shown for one cycle with done_o high. The
// receiver cannot stall, so results leave as soon as they are made. Open,
// put, close and every refused command are answered from the idle state;
// enumerate and next with a record first read the order memory, then the
// record memory. Flush ranks each stored record against all others through
// the single key memory read port. A record's rank counts smaller keys
// plus equal keys that arrived earlier, which keeps the order stable.
// Configuration writes are always ready and apply at once.
`default_nettype none
module stable_record_sorter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [63:0] record_key_i,
  input  wire logic [3:0]  key_size_i,
  input  wire logic [63:0] record_data_i,
  input  wire logic [3:0]  data_size_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_index_i,
  input  wire logic [3:0]  cfg_data_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic             record_valid_o,
  output logic [63:0]      out_key_o,
  output logic [63:0]      out_data_o
);

  logic          cmd_valid, cmd_pop;
  srs_pkg::cmd_t cmd;
  srs_pkg::res_t res;

  // decode and hold commands
  srs_front u_front (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .kind_i, .record_key_i, .key_size_i, .record_data_i, .data_size_i,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  // execute commands, one at a time
  srs_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .res_o(res)
  );

  assign done_o         = res.done;
  assign status_o       = res.status;
  assign record_valid_o = res.record_valid;
  assign out_key_o      = res.key;
  assign out_data_o     = res.data;

endmodule
`default_nettype wire

@@ hdl/srs_checker.sv @@
// Port-level checker for the stable record sorter, bound to the top level.
// Depends on srs_pkg and stable_record_sorter_unit.
`default_nettype none
module srs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        done_o,
  input wire logic [2:0]  status_o,
  input wire logic        record_valid_o,
  input wire logic [63:0] out_key_o,
  input wire logic [63:0] out_data_o,
  input wire logic        cfg_ready_o
);

  a_rec_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    record_valid_o |-> done_o && status_o == srs_pkg::ST_OK)
    else $error("record shown without ok status");

  a_no_rec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !record_valid_o |-> out_key_o == 64'd0 && out_data_o == 64'd0)
    else $error("record fields nonzero without record");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind stable_record_sorter_unit srs_checker u_srs_checker (
  .clk_i, .rst_ni, .done_o, .status_o, .record_valid_o,
  .out_key_o, .out_data_o, .cfg_ready_o
);
`default_nettype wire
